// ===== rtl/core/sev_pkg.sv =====
// Shared types and constants for the slope engine voice unit.
package sev_pkg;

  // Register interface widths.
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  // Register indexes (byte address = 4 * index).
  localparam logic [1:0] REG_PHASE_INC = 2'd0;
  localparam logic [1:0] REG_RANGE     = 2'd1;
  localparam logic [1:0] REG_MODE      = 2'd2;

  // Slope mode codes; the unused code behaves as sustain.
  localparam logic [1:0] MODE_TRANSIENT = 2'd0;
  localparam logic [1:0] MODE_SUSTAIN   = 2'd1;
  localparam logic [1:0] MODE_CYCLE     = 2'd2;

  // Trigger gate threshold: 0.5 in Q3.12.
  localparam logic signed [15:0] GATE_THRESHOLD = 16'sd2048;

  // Largest accepted increment: one half of 2^16.
  localparam logic [15:0] INC_CAP = 16'h8000;

  // Output scale: 1.0 on the 18-bit result.
  localparam logic [17:0] OUT_ONE = 18'h10000;

  typedef struct packed {
    logic [15:0] phase_increment;
    logic        range_sound;
    logic [1:0]  slope_mode;
  } cfg_t;

endpackage

// ===== rtl/core/sev_cfg_regs.sv =====
// Configuration register file behind the APB-style port.
module sev_cfg_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [sev_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [sev_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [sev_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                             pready,
  output sev_pkg::cfg_t                    cfg
);

  logic       wr_en;
  logic [1:0] reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_sel = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.phase_increment <= '0;
      cfg.range_sound     <= 1'b0;
      cfg.slope_mode      <= sev_pkg::MODE_CYCLE;
    end else if (wr_en) begin
      unique case (reg_sel)
        sev_pkg::REG_PHASE_INC: cfg.phase_increment <= pwdata[15:0];
        sev_pkg::REG_RANGE:     cfg.range_sound     <= pwdata[0];
        sev_pkg::REG_MODE:      cfg.slope_mode      <= pwdata[1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_sel)
      sev_pkg::REG_PHASE_INC: prdata[15:0] = cfg.phase_increment;
      sev_pkg::REG_RANGE:     prdata[0]    = cfg.range_sound;
      sev_pkg::REG_MODE:      prdata[1:0]  = cfg.slope_mode;
      default:                prdata       = '0;
    endcase
  end

endmodule

// ===== rtl/core/sev_slope_core.sv =====
// Slope state (phase, one-shot, gate) and the combinational shaping path.
module sev_slope_core #(
  parameter int PHASE_FRAC_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       step_en,
  input  logic signed [15:0]         trigger_sample,
  input  sev_pkg::cfg_t              cfg,
  output logic [17:0]                result,
  output logic [PHASE_FRAC_BITS:0]   phase
);

  localparam int PW = PHASE_FRAC_BITS + 1;
  localparam int SW = PHASE_FRAC_BITS + 2;
  localparam logic [PW-1:0] PHASE_ONE  = {1'b1, {PHASE_FRAC_BITS{1'b0}}};
  localparam logic [PW-1:0] PHASE_HALF = {2'b01, {(PHASE_FRAC_BITS-1){1'b0}}};
  localparam logic [SW-1:0] SUM_ONE    = {1'b0, PHASE_ONE};

  logic                            oneshot_running;
  logic                            gate_held;
  logic                            last_gate;

  logic                            gate, rise, fall;
  logic [15:0]                     inc_capped;
  logic [PHASE_FRAC_BITS+15:0]     inc_wide;
  logic [PHASE_FRAC_BITS-1:0]      inc;
  logic [SW-1:0]                   inc_ext;
  logic                            is_cycle, is_transient, is_sustain;
  logic                            start, run;
  logic [SW-1:0]                   base, sum, sum_wrap;
  logic [PW-1:0]                   phase_next;
  logic                            running_next, held_next;
  logic [PW-1:0]                   shaped;
  logic [PW+15:0]                  shaped_wide;
  logic [16:0]                     s17;

  assign gate = trigger_sample > sev_pkg::GATE_THRESHOLD;
  assign rise = gate & ~last_gate;
  assign fall = ~gate & last_gate;

  // Scale the 16-bit increment to the phase fraction.
  assign inc_capped = (cfg.phase_increment > sev_pkg::INC_CAP) ? sev_pkg::INC_CAP
                                                              : cfg.phase_increment;
  assign inc_wide   = {inc_capped, {PHASE_FRAC_BITS{1'b0}}};
  assign inc        = inc_wide[PHASE_FRAC_BITS+15:16];
  assign inc_ext    = SW'(inc);

  assign is_cycle     = (cfg.slope_mode == sev_pkg::MODE_CYCLE);
  assign is_transient = (cfg.slope_mode == sev_pkg::MODE_TRANSIENT);
  assign is_sustain   = ~is_cycle & ~is_transient;

  assign start = rise & ~oneshot_running;
  assign run   = oneshot_running | start;

  always_comb begin
    held_next    = gate_held;
    running_next = oneshot_running;
    base         = {1'b0, phase};
    if (is_transient && start) begin
      base = '0;
    end
    sum      = base + inc_ext;
    sum_wrap = (sum >= SUM_ONE) ? sum - SUM_ONE : sum;
    phase_next = phase;
    if (is_cycle) begin
      phase_next = rise ? '0 : sum_wrap[PW-1:0];
    end else if (is_transient) begin
      if (run) begin
        if (sum >= SUM_ONE) begin
          phase_next   = '0;
          running_next = 1'b0;
        end else begin
          phase_next   = sum[PW-1:0];
          running_next = 1'b1;
        end
      end else begin
        phase_next = '0;
      end
    end else begin
      if (rise) begin
        held_next = 1'b1;
      end else if (fall) begin
        held_next = 1'b0;
      end
      if (held_next) begin
        phase_next = (sum > SUM_ONE) ? PHASE_ONE : sum[PW-1:0];
      end else begin
        phase_next = (phase > PW'(inc)) ? phase - PW'(inc) : '0;
      end
    end
  end

  // Fold to a triangle outside sustain.
  always_comb begin
    if (is_sustain) begin
      shaped = phase_next;
    end else if (phase_next < PHASE_HALF) begin
      shaped = {phase_next[PW-2:0], 1'b0};
    end else begin
      shaped = PHASE_ONE - phase_next;
      shaped = {shaped[PW-2:0], 1'b0};
    end
  end

  assign shaped_wide = {shaped, 16'h0000};
  assign s17         = shaped_wide[PHASE_FRAC_BITS+16:PHASE_FRAC_BITS];
  assign result      = cfg.range_sound ? ({s17, 1'b0} - sev_pkg::OUT_ONE) : {1'b0, s17};

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= '0;
      oneshot_running <= 1'b0;
      gate_held       <= 1'b0;
      last_gate       <= 1'b0;
    end else if (step_en) begin
      phase           <= phase_next;
      oneshot_running <= running_next;
      gate_held       <= held_next;
      last_gate       <= gate;
    end
  end

endmodule

// ===== rtl/core/slope_engine_voice_unit.sv =====
// Top level of the slope engine voice: input stage, slope core, result register.
//
// One voice of a phase-accumulator function generator. Each trigger_sample
// transaction on the input channel (in_valid / in_stall) produces exactly one
// voice_out transaction on the output channel (out_valid / out_stall).
// The mode, increment and output range come from an APB-style register port;
// write it only while no transaction is in flight.
//
// A sample that is accepted lands in the input register, is stepped through
// the slope core and captured in the result register when the core steps;
// out_valid is high from then until the receiver takes it.
// Throughput: one transaction per cycle while the receiver does not stall, set
// by the single add/compare/fold path between the input and result registers.
// When the receiver stalls, the result register holds its value and the input
// register can still take one more sample; in_stall rises only when both are
// full. Synchronous reset empties both stages, clears phase, one-shot and gate
// state, and loads register defaults (increment 0, shape range, cycle mode).
module slope_engine_voice_unit #(
  parameter int PHASE_FRAC_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic signed [15:0]              trigger_sample,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic signed [17:0]              voice_out,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [sev_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [sev_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [sev_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                            pready
);

  sev_pkg::cfg_t             cfg;
  logic                      in_full;
  logic signed [15:0]        in_sample;
  logic                      in_accept;
  logic                      fire;
  logic [17:0]               result;
  logic [PHASE_FRAC_BITS:0]  phase;

  sev_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Step the core when a sample is waiting and the result register is free or being taken.
  assign fire      = in_full & (~out_valid | ~out_stall);
  assign in_stall  = in_full & ~fire;
  assign in_accept = in_valid & ~in_stall;

  sev_slope_core #(
    .PHASE_FRAC_BITS (PHASE_FRAC_BITS)
  ) u_core (
    .clk            (clk),
    .rst            (rst),
    .step_en        (fire),
    .trigger_sample (in_sample),
    .cfg            (cfg),
    .result         (result),
    .phase          (phase)
  );

  // Input register: fill on accept, drain when the core steps.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_accept) begin
      in_full <= 1'b1;
    end else if (fire) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      in_sample <= trigger_sample;
    end
  end

  // Result register: load on step, hold while stalled, drop once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= fire | (out_valid & out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      voice_out <= $signed(result);
    end
  end

  // Back-pressure only while the input stage holds a sample.
  a_stall_needs_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> in_full)
    else $error("input stalled with empty input stage");

  // The phase never exceeds 1.0.
  a_phase_bound: assert property (@(posedge clk) disable iff (rst)
    phase <= {1'b1, {PHASE_FRAC_BITS{1'b0}}})
    else $error("phase above one");

  // A new result appears only after a core step.
  a_result_from_step: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(fire))
    else $error("result valid without a core step");

  // A stalled result is not replaced by a new step.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |-> !fire)
    else $error("core stepped over a waiting result");

endmodule
